@@ sv/particle_contact_friction_correction_defines.svh @@
// Assertion macros shared by the particle contact correction RTL.
`ifndef PARTICLE_CONTACT_FRICTION_CORRECTION_DEFINES_SVH
`define PARTICLE_CONTACT_FRICTION_CORRECTION_DEFINES_SVH
`ifndef SYNTH
`define PCFC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("pcfc: assertion failed");
`define PCFC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcfc: assertion failed");
`else
`define PCFC_ASSERT(lbl, prop)
`define PCFC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/pcfc_pkg.sv @@
package pcfc_pkg;

	localparam int IDX_W      = 12;
	localparam int POS_W      = 32;
	localparam int RAD_W      = 31;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 32;
	localparam int PIPE_DEPTH = 4 + 1 + SQRT_STEPS + 2 + 1 + DIV_STEPS + 1 + 1 + DIV_STEPS + 1;

	localparam logic [CFG_W-1:0] KINETIC_RESET = 16'd22938;
	localparam logic [CFG_W-1:0] STATIC_RESET  = 16'd19661;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KINETIC = 1'b0,
		CFG_STATIC  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0]        index_a;
		logic [IDX_W-1:0]        index_b;
		logic signed [POS_W-1:0] pos_a_x;
		logic signed [POS_W-1:0] pos_a_y;
		logic signed [POS_W-1:0] pos_a_z;
		logic signed [POS_W-1:0] pos_b_x;
		logic signed [POS_W-1:0] pos_b_y;
		logic signed [POS_W-1:0] pos_b_z;
		logic [RAD_W-1:0]        radius_a;
		logic [RAD_W-1:0]        radius_b;
		logic [RAD_W-1:0]        mass_a;
		logic [RAD_W-1:0]        mass_b;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]        tag_a;
		logic [IDX_W-1:0]        tag_b;
		logic signed [POS_W-1:0] shift_a_x;
		logic signed [POS_W-1:0] shift_a_y;
		logic signed [POS_W-1:0] shift_a_z;
		logic signed [POS_W-1:0] shift_b_x;
		logic signed [POS_W-1:0] shift_b_y;
		logic signed [POS_W-1:0] shift_b_z;
		logic                    in_contact;
		logic                    static_case;
	} out_item_t;

	// Per-pair values that ride along the pipeline beside the arithmetic.
	typedef struct packed {
		logic [IDX_W-1:0]           tag_a;
		logic [IDX_W-1:0]           tag_b;
		logic [2:0]                 neg;
		logic [2:0][POS_W-1:0]      mag;
		logic                       contact;
		logic                       nonzero;
		logic [RAD_W-1:0]           ma;
		logic [RAD_W-1:0]           mb;
		logic [POS_W-1:0]           msum;
		logic [POS_W-1:0]           diam;
		logic [POS_W-1:0]           root;
	} side_t;

	typedef struct packed {
		logic [POS_W+1:0] rem;
		logic [POS_W-1:0] root;
	} rt_step_t;

	typedef struct packed {
		logic [POS_W-1:0] rem;
		logic             qb;
	} dv_step_t;

	// One digit of the restoring integer square root.
	function automatic rt_step_t rt_step(logic [POS_W+1:0] rem, logic [POS_W-1:0] root,
			logic [1:0] pair);
		logic [POS_W+3:0] sh;
		logic [POS_W+3:0] trial;
		rt_step_t r;
		sh    = {rem, pair};
		trial = {2'b00, root, 2'b01};
		if (sh >= trial) begin
			r.rem  = (POS_W+2)'(sh - trial);
			r.root = {root[POS_W-2:0], 1'b1};
		end else begin
			r.rem  = sh[POS_W+1:0];
			r.root = {root[POS_W-2:0], 1'b0};
		end
		return r;
	endfunction

	// One quotient bit of a restoring division; the remainder stays below den.
	function automatic dv_step_t dv_step(logic [POS_W-1:0] rem, logic nb, logic [POS_W-1:0] den);
		logic [POS_W:0] sh;
		dv_step_t r;
		sh = {rem, nb};
		if (sh >= {1'b0, den}) begin
			r.rem = POS_W'(sh - {1'b0, den});
			r.qb  = 1'b1;
		end else begin
			r.rem = sh[POS_W-1:0];
			r.qb  = 1'b0;
		end
		return r;
	endfunction

	// Apply the sign to a magnitude and saturate to the signed 32-bit range.
	function automatic logic signed [POS_W-1:0] sat_shift(logic neg, logic [POS_W-1:0] mag);
		logic signed [POS_W-1:0] v;
		if (neg) begin
			v = mag[POS_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : -$signed(mag);
		end else begin
			v = mag[POS_W-1] ? {1'b0, {(POS_W-1){1'b1}}} : $signed(mag);
		end
		return v;
	endfunction

endpackage

@@ sv/pcfc_datapath.sv @@
module pcfc_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  pcfc_pkg::in_item_t   in_data,
	input  logic                 static_on,
	output logic                 out_valid,
	output pcfc_pkg::out_item_t  out_data
);
	import pcfc_pkg::*;

	logic [PIPE_DEPTH-1:0] vld_s;

	logic [IDX_W-1:0]       tag_a_s1, tag_b_s1;
	logic [2:0][POS_W:0]    dlt_s1;
	logic [POS_W-1:0]       diam_s1;
	logic [RAD_W-1:0]       ma_s1, mb_s1;

	side_t                  side_s2;
	logic [2:0]             magtop_s2;

	side_t                  side_s3;
	logic [2:0]             far_s3;
	logic [2:0][2*POS_W-1:0] sq_s3;
	logic [2*POS_W-1:0]     dsq_s3;

	side_t                  side_s4;
	logic                   far_s4;
	logic [2*POS_W+1:0]     d2_s4;
	logic [2*POS_W-1:0]     dsq_s4;

	side_t                  rt_side_s [0:SQRT_STEPS];
	logic [2*POS_W-1:0]     rt_rad_s  [0:SQRT_STEPS];
	logic [POS_W+1:0]       rt_rem_s  [0:SQRT_STEPS];
	logic [POS_W-1:0]       rt_root_s [0:SQRT_STEPS];

	side_t                  side_s6;
	logic [POS_W-1:0]       pen_s6;

	side_t                  side_s7;
	logic [2:0][2*POS_W-1:0] prod_s7;

	side_t                  d1_side_s [0:DIV_STEPS];
	logic [2:0][2*POS_W:0]  d1_num_s  [0:DIV_STEPS];
	logic [2:0][POS_W-1:0]  d1_rem_s  [0:DIV_STEPS];
	logic [2:0][POS_W-1:0]  d1_q_s    [0:DIV_STEPS];

	side_t                  side_s9;
	logic [5:0][2*POS_W-1:0] mul_s9;

	side_t                  d2_side_s [0:DIV_STEPS];
	logic [5:0][2*POS_W:0]  d2_num_s  [0:DIV_STEPS];
	logic [5:0][POS_W-1:0]  d2_rem_s  [0:DIV_STEPS];
	logic [5:0][POS_W-1:0]  d2_q_s    [0:DIV_STEPS];

	out_item_t              out_s11;

	// Combinational helpers
	logic [2:0][POS_W-1:0]  pos_a, pos_b;
	logic [2:0][POS_W:0]    mag_c;
	logic [RAD_W-1:0]       ma_c, mb_c;
	side_t                  side_c2, side_c5, side_c6;
	rt_step_t               rt_nx [0:SQRT_STEPS-1];
	dv_step_t               dv1_nx [0:DIV_STEPS-1][0:2];
	dv_step_t               dv2_nx [0:DIV_STEPS-1][0:5];
	logic [2:0][2*POS_W:0]  num1_c;
	logic [5:0][2*POS_W:0]  num2_c;
	logic                   live_c;

	always_comb begin
		pos_a = {in_data.pos_a_z, in_data.pos_a_y, in_data.pos_a_x};
		pos_b = {in_data.pos_b_z, in_data.pos_b_y, in_data.pos_b_x};
		for (int k = 0; k < 3; k++) begin
			mag_c[k] = dlt_s1[k][POS_W] ? (POS_W+1)'(-dlt_s1[k]) : dlt_s1[k];
		end
		// Two massless particles split the correction evenly.
		if (ma_s1 == '0 && mb_s1 == '0) begin
			ma_c = RAD_W'(1);
			mb_c = RAD_W'(1);
		end else begin
			ma_c = ma_s1;
			mb_c = mb_s1;
		end
		side_c2         = '0;
		side_c2.tag_a   = tag_a_s1;
		side_c2.tag_b   = tag_b_s1;
		for (int k = 0; k < 3; k++) begin
			side_c2.neg[k] = dlt_s1[k][POS_W];
			side_c2.mag[k] = mag_c[k][POS_W-1:0];
		end
		side_c2.ma      = ma_c;
		side_c2.mb      = mb_c;
		side_c2.msum    = {1'b0, ma_c} + {1'b0, mb_c};
		side_c2.diam    = diam_s1;

		side_c5         = side_s4;
		side_c5.contact = !far_s4 && (d2_s4 < {2'b00, dsq_s4});
		side_c5.nonzero = (d2_s4 != '0);

		side_c6         = rt_side_s[SQRT_STEPS];
		side_c6.root    = rt_root_s[SQRT_STEPS];

		for (int j = 0; j < SQRT_STEPS; j++) begin
			rt_nx[j] = rt_step(rt_rem_s[j], rt_root_s[j],
				rt_rad_s[j][2*(SQRT_STEPS-1-j) +: 2]);
		end
		for (int k = 0; k < 3; k++) begin
			num1_c[k] = {1'b0, prod_s7[k]} + (2*POS_W+1)'(side_s7.root >> 1);
		end
		for (int j = 0; j < DIV_STEPS; j++) begin
			for (int k = 0; k < 3; k++) begin
				dv1_nx[j][k] = dv_step(d1_rem_s[j][k], d1_num_s[j][k][DIV_STEPS-1-j],
					d1_side_s[j].root);
			end
		end
		for (int k = 0; k < 6; k++) begin
			num2_c[k] = {1'b0, mul_s9[k]} + (2*POS_W+1)'(side_s9.msum >> 1);
		end
		for (int j = 0; j < DIV_STEPS; j++) begin
			for (int k = 0; k < 6; k++) begin
				dv2_nx[j][k] = dv_step(d2_rem_s[j][k], d2_num_s[j][k][DIV_STEPS-1-j],
					d2_side_s[j].msum);
			end
		end
		live_c = d2_side_s[DIV_STEPS].contact && d2_side_s[DIV_STEPS].nonzero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[PIPE_DEPTH-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Separation per axis and summed radii.
			tag_a_s1 <= in_data.index_a;
			tag_b_s1 <= in_data.index_b;
			for (int k = 0; k < 3; k++) begin
				dlt_s1[k] <= {pos_a[k][POS_W-1], pos_a[k]} - {pos_b[k][POS_W-1], pos_b[k]};
			end
			diam_s1 <= {1'b0, in_data.radius_a} + {1'b0, in_data.radius_b};
			ma_s1   <= in_data.mass_a;
			mb_s1   <= in_data.mass_b;

			// Magnitudes and mass sum.
			side_s2 <= side_c2;
			for (int k = 0; k < 3; k++) begin
				magtop_s2[k] <= mag_c[k][POS_W];
			end

			// Axis gap test and squares.
			side_s3 <= side_s2;
			for (int k = 0; k < 3; k++) begin
				far_s3[k] <= magtop_s2[k] || (side_s2.mag[k] >= side_s2.diam);
				sq_s3[k]  <= side_s2.mag[k] * side_s2.mag[k];
			end
			dsq_s3 <= side_s2.diam * side_s2.diam;

			// Squared length.
			side_s4 <= side_s3;
			far_s4  <= |far_s3;
			d2_s4   <= {2'b00, sq_s3[0]} + {2'b00, sq_s3[1]} + {2'b00, sq_s3[2]};
			dsq_s4  <= dsq_s3;

			// Square root, one result bit per stage.
			rt_side_s[0] <= side_c5;
			rt_rad_s[0]  <= d2_s4[2*POS_W-1:0];
			rt_rem_s[0]  <= '0;
			rt_root_s[0] <= '0;
			for (int j = 0; j < SQRT_STEPS; j++) begin
				rt_side_s[j+1] <= rt_side_s[j];
				rt_rad_s[j+1]  <= rt_rad_s[j];
				rt_rem_s[j+1]  <= rt_nx[j].rem;
				rt_root_s[j+1] <= rt_nx[j].root;
			end

			// Penetration depth, then penetration times each axis magnitude.
			side_s6 <= side_c6;
			pen_s6  <= rt_side_s[SQRT_STEPS].diam - rt_root_s[SQRT_STEPS];
			side_s7 <= side_s6;
			for (int k = 0; k < 3; k++) begin
				prod_s7[k] <= pen_s6 * side_s6.mag[k];
			end

			// Per-axis correction: rounded division by the length.
			d1_side_s[0] <= side_s7;
			for (int k = 0; k < 3; k++) begin
				d1_num_s[0][k] <= num1_c[k];
				d1_rem_s[0][k] <= num1_c[k][2*POS_W-1:POS_W];
				d1_q_s[0][k]   <= '0;
			end
			for (int j = 0; j < DIV_STEPS; j++) begin
				d1_side_s[j+1] <= d1_side_s[j];
				d1_num_s[j+1]  <= d1_num_s[j];
				for (int k = 0; k < 3; k++) begin
					d1_rem_s[j+1][k] <= dv1_nx[j][k].rem;
					d1_q_s[j+1][k]   <= {d1_q_s[j][k][POS_W-2:0], dv1_nx[j][k].qb};
				end
			end

			// Mass weighting: lanes 0 to 2 for particle a, 3 to 5 for b.
			side_s9 <= d1_side_s[DIV_STEPS];
			for (int k = 0; k < 3; k++) begin
				mul_s9[k]   <= d1_q_s[DIV_STEPS][k] * d1_side_s[DIV_STEPS].mb;
				mul_s9[k+3] <= d1_q_s[DIV_STEPS][k] * d1_side_s[DIV_STEPS].ma;
			end

			d2_side_s[0] <= side_s9;
			for (int k = 0; k < 6; k++) begin
				d2_num_s[0][k] <= num2_c[k];
				d2_rem_s[0][k] <= num2_c[k][2*POS_W-1:POS_W];
				d2_q_s[0][k]   <= '0;
			end
			for (int j = 0; j < DIV_STEPS; j++) begin
				d2_side_s[j+1] <= d2_side_s[j];
				d2_num_s[j+1]  <= d2_num_s[j];
				for (int k = 0; k < 6; k++) begin
					d2_rem_s[j+1][k] <= dv2_nx[j][k].rem;
					d2_q_s[j+1][k]   <= {d2_q_s[j][k][POS_W-2:0], dv2_nx[j][k].qb};
				end
			end

			// Sign, saturation and the no-contact and coincident cases.
			out_s11.tag_a       <= d2_side_s[DIV_STEPS].tag_a;
			out_s11.tag_b       <= d2_side_s[DIV_STEPS].tag_b;
			out_s11.in_contact  <= d2_side_s[DIV_STEPS].contact;
			out_s11.static_case <= d2_side_s[DIV_STEPS].contact && static_on;
			if (live_c) begin
				out_s11.shift_a_x <= sat_shift(d2_side_s[DIV_STEPS].neg[0], d2_q_s[DIV_STEPS][0]);
				out_s11.shift_a_y <= sat_shift(d2_side_s[DIV_STEPS].neg[1], d2_q_s[DIV_STEPS][1]);
				out_s11.shift_a_z <= sat_shift(d2_side_s[DIV_STEPS].neg[2], d2_q_s[DIV_STEPS][2]);
				out_s11.shift_b_x <= sat_shift(!d2_side_s[DIV_STEPS].neg[0], d2_q_s[DIV_STEPS][3]);
				out_s11.shift_b_y <= sat_shift(!d2_side_s[DIV_STEPS].neg[1], d2_q_s[DIV_STEPS][4]);
				out_s11.shift_b_z <= sat_shift(!d2_side_s[DIV_STEPS].neg[2], d2_q_s[DIV_STEPS][5]);
			end else begin
				out_s11.shift_a_x <= '0;
				out_s11.shift_a_y <= '0;
				out_s11.shift_a_z <= '0;
				out_s11.shift_b_x <= '0;
				out_s11.shift_b_y <= '0;
				out_s11.shift_b_z <= '0;
			end
		end
	end

	assign out_valid = vld_s[PIPE_DEPTH-1];
	assign out_data  = out_s11;

endmodule

@@ sv/particle_contact_friction_correction.sv @@
// Particle contact correction with friction for position-based dynamics.
// The pair channel (pair_valid, pair_stall, pair) takes one neighbor pair per
// transaction: two tags, two Q16.16 positions, radii and masses. The result
// channel (result_valid, result_stall, result) returns one transaction per pair,
// in order, with both particles' corrections and the contact and static flags.
// The cfg channel writes the kinetic (index 0) and static (index 1) friction
// coefficients; it is always ready and should be used only while the block is idle.
// One pair can be accepted every clock cycle while pair_stall is low. Each accepted
// pair runs through a 107-stage pipeline set by the 32-step square root and
// the two 32-step rounded dividers.
// A two-entry output queue sits behind the pipeline, so a new pair is still taken
// while a finished result waits. When that queue is full, pair_stall rises and
// the whole pipeline holds, losing and repeating nothing.
// Reset empties the pipeline and the queue and loads the coefficients with
// their defaults (about 0.35 kinetic and 0.30 static).
`include "particle_contact_friction_correction_defines.svh"

module particle_contact_friction_correction (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pair_valid,
	output logic                                pair_stall,
	input  pcfc_pkg::in_item_t                  pair,
	output logic                                result_valid,
	input  logic                                result_stall,
	output pcfc_pkg::out_item_t                 result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pcfc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pcfc_pkg::CFG_W-1:0]          cfg_data
);
	import pcfc_pkg::*;

	// Coefficient registers. The kinetic coefficient only ever scales a zero
	// tangential vector, so it is stored but does not reach the datapath.
	logic [CFG_W-1:0] kin_q;
	logic [CFG_W-1:0] stat_q;

	// Output queue: two entries, read pointer, write pointer and fill count.
	out_item_t        ent_q [2];
	logic             rd_q;
	logic             wr_q;
	logic [1:0]       cnt_q;

	logic             adv;
	logic             push;
	logic             pop;
	logic             dp_valid;
	out_item_t        dp_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kin_q  <= KINETIC_RESET;
			stat_q <= STATIC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_KINETIC: begin
					kin_q <= cfg_data;
				end
				CFG_STATIC: begin
					stat_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// The pipeline moves whenever the queue has a free slot. The decision comes
	// from the registered count only, which keeps the stall path short.
	assign adv        = (cnt_q != 2'd2);
	assign pair_stall = !adv;
	assign push       = adv && dp_valid;
	assign pop        = result_valid && !result_stall;

	pcfc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (pair_valid),
		.in_data   (pair),
		.static_on (stat_q != '0),
		.out_valid (dp_valid),
		.out_data  (dp_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10: begin
					cnt_q <= cnt_q + 2'd1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 2'd1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= dp_data;
		end
	end

	assign result_valid = (cnt_q != 2'd0);
	assign result       = ent_q[rd_q];

	`PCFC_ASSERT(a_cnt_range, cnt_q != 2'd3)
	`PCFC_ASSERT(a_static_has_contact, !(result_valid && result.static_case && !result.in_contact))
	`PCFC_ASSERT_NEXT(a_last_pop_drains, pop && !push && cnt_q == 2'd1, !result_valid)
	`PCFC_ASSERT(a_miss_is_zero, !(result_valid && !result.in_contact && (result.shift_a_x != '0 || result.shift_a_y != '0 || result.shift_a_z != '0 || result.shift_b_x != '0 || result.shift_b_y != '0 || result.shift_b_z != '0)))

endmodule

@@ test/tb_particle_contact_friction_correction.sv @@
module tb_particle_contact_friction_correction;
	timeunit 1ns;
	timeprecision 1ps;
	import pcfc_pkg::*;

	// Every drain waits a little longer than the pipeline is deep.
	localparam int SETTLE_CYCLES = 130;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 500;

	logic              clk;
	logic              arst_n;
	logic              pair_valid;
	logic              pair_stall;
	in_item_t          pair;
	logic              result_valid;
	logic              result_stall;
	out_item_t         result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]  cfg_data;

	particle_contact_friction_correction DUT (
		.clk(clk), .arst_n(arst_n),
		.pair_valid(pair_valid), .pair_stall(pair_stall), .pair(pair),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Local copy of the friction coefficients, mirroring the block's registers.
	logic [CFG_W-1:0] kinetic_coef;
	logic [CFG_W-1:0] static_coef;

	out_item_t pending_shifts[$];
	int        error_count;
	int        pairs_sent;
	int        results_seen;
	int        contacts_seen;
	int        cycle_count;
	bit        idle_on;
	logic      holding;
	event      hold_go;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Rounded division, half up, wide enough that the sum never wraps.
	function automatic logic [127:0] round_div(logic [127:0] num, logic [127:0] den);
		return (num + den / 2) / den;
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [65:0] v);
		logic [65:0] r;
		logic [65:0] t;
		r = '0;
		for (int b = 32; b >= 0; b--) begin
			t = r | (66'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r[63:0];
	endfunction

	function automatic logic signed [31:0] signed_sat(bit neg, logic [127:0] mag);
		if (neg)
			return (mag >= 128'h8000_0000) ? 32'sh8000_0000 : -$signed(mag[31:0]);
		return (mag > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
	endfunction

	// Works out the corrections for one pair from the current coefficients.
	function automatic out_item_t contact_shift(in_item_t p);
		out_item_t o;
		logic [63:0] diam;
		logic [63:0] ma;
		logic [63:0] mb;
		logic [63:0] mag[3];
		bit neg[3];
		longint d;
		logic [65:0] d2;
		logic [63:0] root;
		logic [63:0] pen;
		logic [127:0] q;
		logic [127:0] sa;
		logic [127:0] sb;
		logic signed [31:0] sh_a[3];
		logic signed [31:0] sh_b[3];
		bit contact;
		o = '0;
		o.tag_a = p.index_a;
		o.tag_b = p.index_b;
		diam = 64'(p.radius_a) + 64'(p.radius_b);
		ma = 64'(p.mass_a);
		mb = 64'(p.mass_b);
		contact = 1'b1;
		d2 = '0;
		for (int k = 0; k < 3; k++) begin
			case (k)
				0: d = longint'($signed(p.pos_a_x)) - longint'($signed(p.pos_b_x));
				1: d = longint'($signed(p.pos_a_y)) - longint'($signed(p.pos_b_y));
				default: d = longint'($signed(p.pos_a_z)) - longint'($signed(p.pos_b_z));
			endcase
			neg[k] = d < 0;
			mag[k] = neg[k] ? 64'(-d) : 64'(d);
			if (mag[k] >= diam)
				contact = 1'b0;
			d2 = d2 + 66'(mag[k]) * 66'(mag[k]);
		end
		// A sum of squares beyond 64 bits is treated as no overlap.
		if (d2 >= 66'h1_0000_0000_0000_0000 || d2 >= 66'(diam) * 66'(diam))
			contact = 1'b0;
		if (!contact)
			return o;
		o.in_contact = 1'b1;
		o.static_case = (static_coef != '0);
		if (d2 == 0)
			return o;
		if (ma + mb == 0) begin
			ma = 1;
			mb = 1;
		end
		root = floor_sqrt(d2);
		pen = diam - root;
		for (int k = 0; k < 3; k++) begin
			q  = round_div(128'(pen) * 128'(mag[k]), 128'(root));
			sa = round_div(q * 128'(mb), 128'(ma + mb));
			sb = round_div(q * 128'(ma), 128'(ma + mb));
			sh_a[k] = signed_sat(neg[k], sa);
			sh_b[k] = signed_sat(!neg[k] && mag[k] != 0, sb);
		end
		o.shift_a_x = sh_a[0];
		o.shift_a_y = sh_a[1];
		o.shift_a_z = sh_a[2];
		o.shift_b_x = sh_b[0];
		o.shift_b_y = sh_b[1];
		o.shift_b_z = sh_b[2];
		return o;
	endfunction

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			error_count++;
		end
	endtask

	// Offers one pair and holds it until the block takes the transaction.
	task automatic send_pair(in_item_t p);
		while (idle_on && $urandom_range(99) < 8) begin
			pair_valid <= 1'b0;
			@(posedge clk);
		end
		pair_valid <= 1'b1;
		pair <= p;
		@(posedge clk);
		while (pair_stall)
			@(posedge clk);
		pending_shifts = {pending_shifts, contact_shift(p)};
		pairs_sent++;
	endtask

	task automatic end_pairs();
		pair_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every expected result is back, then lets the pipeline settle.
	task automatic drain();
		end_pairs();
		while (pending_shifts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_coef(cfg_reg_t idx, logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_KINETIC)
			kinetic_coef = value;
		else
			static_coef = value;
		@(posedge clk);
	endtask

	function automatic in_item_t noise_pair();
		in_item_t p;
		logic [383:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom};
		p = raw[$bits(in_item_t)-1:0];
		return p;
	endfunction

	// An overlapping or nearly touching pair at a random scale, with random content.
	function automatic in_item_t touching_pair();
		in_item_t p;
		int scale;
		int unsigned span;
		p = noise_pair();
		scale = $urandom_range(29, 2);
		p.radius_a = 31'($urandom) & ((31'd1 << scale) - 1);
		p.radius_b = 31'($urandom) & ((31'd1 << scale) - 1);
		span = (32'(p.radius_a) + 32'(p.radius_b)) / 2 + 1;
		if ($urandom_range(3) == 0)
			span = span * 2;
		p.pos_a_x = $signed($urandom_range(32'h3FFF_FFFF)) - 32'sh2000_0000;
		p.pos_a_y = $signed($urandom_range(32'h3FFF_FFFF)) - 32'sh2000_0000;
		p.pos_a_z = $signed($urandom_range(32'h3FFF_FFFF)) - 32'sh2000_0000;
		p.pos_b_x = p.pos_a_x + $signed($urandom_range(span)) - $signed(span / 2);
		p.pos_b_y = p.pos_a_y + $signed($urandom_range(span)) - $signed(span / 2);
		p.pos_b_z = p.pos_a_z + $signed($urandom_range(span)) - $signed(span / 2);
		case ($urandom_range(3))
			0: begin
				p.mass_a = 31'($urandom_range(65536 * 16, 1));
				p.mass_b = 31'($urandom_range(65536 * 16, 1));
			end
			1: p.mass_a = 31'($urandom_range(255));
			default: ;
		endcase
		return p;
	endfunction

	function automatic in_item_t basic_pair(int ax, int bx, int ra, int rb);
		in_item_t p;
		p = '0;
		p.index_a = 12'($urandom);
		p.index_b = 12'($urandom);
		p.pos_a_x = ax;
		p.pos_b_x = bx;
		p.radius_a = 31'(ra);
		p.radius_b = 31'(rb);
		p.mass_a = 31'(65536);
		p.mass_b = 31'(65536);
		return p;
	endfunction

	// Results are checked in order against the oldest waiting expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (pending_shifts.size() == 0) begin
					$error("result transaction arrived with nothing expected");
					error_count++;
				end else begin
					out_item_t e;
					e = pending_shifts.pop_front();
					check_field("tag_a", e.tag_a, result.tag_a);
					check_field("tag_b", e.tag_b, result.tag_b);
					check_field("shift_a_x", e.shift_a_x, result.shift_a_x);
					check_field("shift_a_y", e.shift_a_y, result.shift_a_y);
					check_field("shift_a_z", e.shift_a_z, result.shift_a_z);
					check_field("shift_b_x", e.shift_b_x, result.shift_b_x);
					check_field("shift_b_y", e.shift_b_y, result.shift_b_y);
					check_field("shift_b_z", e.shift_b_z, result.shift_b_z);
					check_field("in_contact", e.in_contact, result.in_contact);
					check_field("static_case", e.static_case, result.static_case);
					if (e.in_contact)
						contacts_seen++;
				end
				results_seen++;
			end
			result_stall <= holding || (idle_on && $urandom_range(99) < 8);
		end
	end

	// The long hold-off is timed here, apart from the sender.
	initial begin
		holding = 1'b0;
		forever begin
			@(hold_go);
			@(posedge clk);
			holding <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			holding <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// The special cases: no overlap, touching, zero radii, coincident particles,
	// zero masses, extreme positions, radii and tags.
	task automatic test_directed();
		in_item_t p;
		send_pair(basic_pair(0, 65536 * 3, 65536, 65536));
		send_pair(basic_pair(0, 65536 * 2, 65536, 65536));
		send_pair(basic_pair(0, 65536 * 2 - 1, 65536, 65536));
		send_pair(basic_pair(0, 0, 0, 0));
		send_pair(basic_pair(0, 1, 0, 0));
		send_pair(basic_pair(12345, 12345, 65536, 0));
		send_pair(basic_pair(-65536, 65536, 65536 * 3, 65536));
		p = basic_pair(0, 100, 65536, 65536);
		p.mass_a = '0;
		send_pair(p);
		p.mass_a = 31'(65536);
		p.mass_b = '0;
		send_pair(p);
		p.mass_a = '0;
		send_pair(p);
		p = basic_pair(32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
		p.radius_a = '1;
		p.radius_b = '1;
		p.index_a = '1;
		p.index_b = '0;
		send_pair(p);
		p.pos_b_x = 32'h7FFF_0000;
		p.pos_a_y = 32'h8000_0000;
		p.pos_b_y = 32'h8000_1000;
		p.mass_a = '1;
		p.mass_b = 31'd1;
		send_pair(p);
		p.mass_a = 31'd1;
		p.mass_b = '1;
		send_pair(p);
		// Off-axis pairs whose x separation equals the diameter, so they do not touch.
		p = basic_pair(65536, 0, 65536, 0);
		p.pos_a_y = 65536;
		send_pair(p);
		p.pos_a_y = -100;
		p.pos_a_z = 300;
		send_pair(p);
		// Exactly touching: the squared distance equals the squared diameter.
		p = basic_pair(3, 0, 2, 3);
		p.pos_a_y = 4;
		send_pair(p);
		send_pair(noise_pair());
		send_pair(noise_pair());
		drain();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++)
			send_pair(($urandom_range(9) < 8) ? touching_pair() : noise_pair());
		drain();
	endtask

	// The receiver stops for a long while and the sender keeps offering pairs,
	// so the pipeline and its output queue fill and the input stalls.
	task automatic test_backpressure();
		-> hold_go;
		for (int i = 0; i < 150; i++)
			send_pair(touching_pair());
		drain();
	endtask

	task automatic test_coef(logic [CFG_W-1:0] kin, logic [CFG_W-1:0] stat, int count);
		write_coef(CFG_KINETIC, kin);
		write_coef(CFG_STATIC, stat);
		test_random(count);
	endtask

	initial begin
		arst_n = 1'b0;
		pair_valid = 1'b0;
		pair = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_KINETIC;
		cfg_data = '0;
		kinetic_coef = KINETIC_RESET;
		static_coef = STATIC_RESET;
		error_count = 0;
		pairs_sent = 0;
		results_seen = 0;
		contacts_seen = 0;
		cycle_count = 0;
		idle_on = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		// A stretch with no idling on either side.
		idle_on = 1'b0;
		test_random(150);
		idle_on = 1'b1;
		test_random(100);
		test_backpressure();
		test_coef('0, '0, 100);
		test_coef('1, '1, 80);
		test_coef(16'($urandom), 16'd0, 40);
		test_coef(16'd0, 16'($urandom_range(65535, 1)), 40);

		$display("Sent %0d pairs and checked %0d results, %0d in contact,", pairs_sent,
			results_seen, contacts_seen);
		$display("over default, zero, full and random friction settings with back-pressure.");
		if (error_count == 0 && pending_shifts.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
